### rtl/pks_pkg.sv
`timescale 1ns / 1ps

package pks_pkg;

  localparam int unsigned SLOTS        = 46;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned ADDR_W       = 40;
  localparam int unsigned KEY_W        = 64;
  localparam int unsigned CUR_W        = 6;
  localparam int unsigned SLOT_FIELD_W = 6;
  localparam int unsigned SLOT_W       = $clog2(SLOTS + 1);
  localparam int unsigned IDX_W        = $clog2(SLOTS);

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_STORE  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NEXT   = 2'd3
  } op_e;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0]  key_high;
    logic [KEY_W-1:0]  key_low;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic                    found;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [ADDR_W-1:0]       result_address;
    logic [KEY_W-1:0]        result_key_high;
    logic [KEY_W-1:0]        result_key_low;
    logic                    was_cleared;
  } result_t;

endpackage

### rtl/pks_in_if.sv
`timescale 1ns / 1ps

interface pks_in_if;
  import pks_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] peer_address;
  logic [KEY_W-1:0]  key_high;
  logic [KEY_W-1:0]  key_low;
  logic [CUR_W-1:0]  cursor;

  modport source (
    output valid, operation, peer_address, key_high, key_low, cursor,
    input  ready
  );

  modport sink (
    input  valid, operation, peer_address, key_high, key_low, cursor,
    output ready
  );
endinterface

### rtl/pks_out_if.sv
`timescale 1ns / 1ps

interface pks_out_if;
  import pks_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    found;
  logic [SLOT_FIELD_W-1:0] slot;
  logic [ADDR_W-1:0]       result_address;
  logic [KEY_W-1:0]        result_key_high;
  logic [KEY_W-1:0]        result_key_low;
  logic                    was_cleared;

  modport source (
    output valid, found, slot, result_address, result_key_high, result_key_low,
           was_cleared,
    input  ready
  );

  modport sink (
    input  valid, found, slot, result_address, result_key_high, result_key_low,
           was_cleared,
    output ready
  );
endinterface

### rtl/pks_ram.sv
`timescale 1ns / 1ps

module pks_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/pks_engine.sv
`timescale 1ns / 1ps

module pks_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  pks_in_if.sink            in_i,
  output pks_pkg::ram_req_t ram_req_o,
  input  pks_pkg::entry_t   ram_rdata_i,
  output pks_pkg::result_t  res_o,
  output logic              res_valid_o,
  input  logic              res_ready_i
);
  import pks_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SCAN    = 5'b00010,
    ST_CAND_RD = 5'b00100,
    ST_CAND_LT = 5'b01000,
    ST_DONE    = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] fill_q, fill_d;
  logic              pend_q, pend_d;
  logic [SLOT_W-1:0] pend_slot_q, pend_slot_d;
  logic [SLOT_W-1:0] cand_q, cand_d;
  logic [SLOT_W-1:0] scan_q, scan_d;
  logic [SLOT_W-1:0] lo_q, lo_d;
  logic              is_next_q, is_next_d;
  logic [ADDR_W-1:0] key_addr_q, key_addr_d;
  result_t           res_q, res_d;

  logic              full;
  logic              issue;
  logic              rd_match;
  logic [CUR_W-1:0]  start_raw;
  logic [SLOT_W-1:0] start;

  assign full      = fill_q >= SLOT_W'(SLOTS);
  assign issue     = scan_q > lo_q;
  assign rd_match  = pend_q && (ram_rdata_i.addr == key_addr_q);
  assign start_raw = (in_i.cursor == '0) ? '0 : in_i.cursor - 1'b1;
  assign start     = (start_raw > CUR_W'(fill_q)) ? fill_q : SLOT_W'(start_raw);

  assign in_i.ready  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    pend_d      = pend_q;
    pend_slot_d = pend_slot_q;
    cand_d      = cand_q;
    scan_d      = scan_q;
    lo_d        = lo_q;
    is_next_d   = is_next_q;
    key_addr_d  = key_addr_q;
    res_d       = res_q;
    ram_req_o   = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          res_d = '0;
          case (op_e'(in_i.operation))
            OP_LOOKUP: begin
              key_addr_d = in_i.peer_address;
              is_next_d  = 1'b0;
              lo_d       = '0;
              scan_d     = fill_q;
              pend_d     = 1'b0;
              state_d    = (fill_q == '0) ? ST_DONE : ST_SCAN;
            end
            OP_STORE: begin
              ram_req_o.we             = 1'b1;
              ram_req_o.waddr          = full ? '0 : fill_q[IDX_W-1:0];
              ram_req_o.wdata.addr     = in_i.peer_address;
              ram_req_o.wdata.key_high = in_i.key_high;
              ram_req_o.wdata.key_low  = in_i.key_low;
              fill_d                   = full ? SLOT_W'(1) : fill_q + 1'b1;
              res_d.slot               = SLOT_FIELD_W'(fill_d);
              res_d.was_cleared        = full;
              state_d                  = ST_DONE;
            end
            OP_CLEAR: begin
              fill_d  = '0;
              state_d = ST_DONE;
            end
            OP_NEXT: begin
              cand_d  = start;
              state_d = (start == '0) ? ST_DONE : ST_CAND_RD;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_CAND_RD: begin
        ram_req_o.raddr = IDX_W'(cand_q - 1'b1);
        state_d         = ST_CAND_LT;
      end
      ST_CAND_LT: begin
        key_addr_d = ram_rdata_i.addr;
        is_next_d  = 1'b1;
        lo_d       = cand_q;
        scan_d     = fill_q;
        pend_d     = 1'b0;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        pend_d = 1'b0;
        if (issue) begin
          ram_req_o.raddr = IDX_W'(scan_q - 1'b1);
          scan_d          = scan_q - 1'b1;
          pend_d          = 1'b1;
          pend_slot_d     = scan_q;
        end
        if (rd_match) begin
          pend_d = 1'b0;
          if (!is_next_q) begin
            res_d.found           = 1'b1;
            res_d.slot            = SLOT_FIELD_W'(pend_slot_q);
            res_d.result_key_high = ram_rdata_i.key_high;
            res_d.result_key_low  = ram_rdata_i.key_low;
            state_d               = ST_DONE;
          end else if (cand_q == SLOT_W'(1)) begin
            state_d = ST_DONE;
          end else begin
            cand_d  = cand_q - 1'b1;
            state_d = ST_CAND_RD;
          end
        end else if (!issue) begin
          if (is_next_q) begin
            res_d.found          = 1'b1;
            res_d.slot           = SLOT_FIELD_W'(cand_q);
            res_d.result_address = key_addr_q;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
    cand_q      <= cand_d;
    scan_q      <= scan_d;
    lo_q        <= lo_d;
    is_next_q   <= is_next_d;
    key_addr_q  <= key_addr_d;
    res_q       <= res_d;
  end

endmodule

### rtl/pairing_key_store_core.sv
`timescale 1ns / 1ps
// one beat at a time: store and clear go straight to the result, lookup scans newest first,
// one stored entry read per cycle from the single entry ram
// next-paired reads each candidate, then scans the newer entries above it,
// so its work is quadratic in the fill count
// the result moves into an output register, so the next beat is taken while it waits
// reset clears the state, fill count and output valid; entry ram contents stay undefined until written

module pairing_key_store_core (
  input logic       clk_i,
  input logic       rst_ni,
  pks_in_if.sink    in_i,
  pks_out_if.source out_o
);
  import pks_pkg::*;

  ram_req_t ram_req;
  entry_t   ram_rdata;
  result_t  res;
  logic     res_valid;
  logic     res_ready;

  logic     out_valid_q, out_valid_d;
  result_t  out_q;

  pks_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready)
  );

  pks_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.found           = out_q.found;
  assign out_o.slot            = out_q.slot;
  assign out_o.result_address  = out_q.result_address;
  assign out_o.result_key_high = out_q.result_key_high;
  assign out_o.result_key_low  = out_q.result_key_low;
  assign out_o.was_cleared     = out_q.was_cleared;

endmodule
